// ===== design/mmh2_pkg.sv =====
// constants and types shared by the murmur2 hash stream block
// no dependencies
package mmh2_pkg;

    typedef logic [31:0] t_word;

    localparam t_word       MIX_MUL     = 32'h5bd1e995;
    localparam int unsigned MIX_SHIFT   = 24;
    localparam int unsigned FIN_SHIFT_A = 13;
    localparam int unsigned FIN_SHIFT_B = 15;

    localparam int unsigned KEY_LEN_W = 32;
    localparam int unsigned BYTE_W    = 8;

endpackage

// ===== design/mmh2_mul.sv =====
// shared multiplier: operand times the mixing constant, low 32 bits, registered
// depends on mmh2_pkg
module mmh2_mul (
    input  logic          i_clk,
    input  logic          i_en,
    input  mmh2_pkg::t_word i_operand,
    output mmh2_pkg::t_word o_product
);
    import mmh2_pkg::*;

    t_word r_prod;
    t_word n_prod;

    // 32-bit context keeps the low half of the product
    assign n_prod = i_operand * MIX_MUL;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_product = r_prod;

endmodule

// ===== design/murmur2_hash_stream.sv =====
// murmur2 hash stream top level: byte sequencer around one shared multiplier
// depends on mmh2_pkg and mmh2_mul
//
//  channel dir  handshake      payload
//  s_axis  in   tvalid/tready  tdata[7:0] data_byte, [39:8] key_length; tlast last_byte
//  m_axis  out  tvalid/tready  tdata[31:0] hash_value
//  seed    in   i_seed_wr_en   i_seed_wr_data
//
// a byte that neither completes a word nor is last stays in S_IDLE; a word-completing
// byte runs S_K1, S_K2, S_H (three passes through the single multiplier). the last
// byte adds finalisation (S_FIN, S_FIN_W), after S_TAIL and S_TAIL_W when leftover
// bytes are folded in first, plus any wait for m_axis to drain the output register.
// a zero-length key skips to S_FIN. reset (synchronous, active low) clears seed and
// key state. the output register lets the next byte be taken while a hash waits.
module murmur2_hash_stream (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_seed_wr_en,
    input  logic [31:0] i_seed_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [7:0] data_byte, [39:8] key_length
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] hash_value
);
    import mmh2_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_K1     = 3'd1;
    localparam logic [2:0] S_K2     = 3'd2;
    localparam logic [2:0] S_H      = 3'd3;
    localparam logic [2:0] S_TAIL   = 3'd4;
    localparam logic [2:0] S_TAIL_W = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;
    localparam logic [2:0] S_FIN_W  = 3'd7;

    logic [2:0]  r_state, n_state;
    t_word       r_seed;
    t_word       r_h, n_h;
    t_word       r_k, n_k;
    logic [23:0] r_pend, n_pend;
    logic [1:0]  r_phase, n_phase;
    logic        r_inside, n_inside;
    logic        r_last, n_last;
    logic        r_out_valid, n_out_valid;
    t_word       r_out, n_out;

    logic        mul_en;
    t_word       mul_op;
    t_word       prod;

    logic [BYTE_W-1:0]    in_byte;
    logic [KEY_LEN_W-1:0] in_len;
    logic                 accept;
    logic                 out_free;
    t_word                base_h;
    logic [23:0]          base_pend;
    logic [1:0]           base_phase;
    t_word                k_shift;
    t_word                fin_res;

    assign in_byte  = s_axis_tdata[7:0];
    assign in_len   = s_axis_tdata[39:8];
    assign s_axis_tready = (r_state == S_IDLE);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    assign base_h     = r_inside ? r_h : (r_seed ^ in_len);
    assign base_pend  = r_inside ? r_pend : 24'd0;
    assign base_phase = r_inside ? r_phase : 2'd0;
    assign k_shift    = prod ^ (prod >> MIX_SHIFT);
    assign fin_res    = prod ^ (prod >> FIN_SHIFT_B);

    mmh2_mul u_mul (
        .i_clk     (i_clk),
        .i_en      (mul_en),
        .i_operand (mul_op),
        .o_product (prod)
    );

    always_comb begin
        n_state     = r_state;
        n_h         = r_h;
        n_k         = r_k;
        n_pend      = r_pend;
        n_phase     = r_phase;
        n_inside    = r_inside;
        n_last      = r_last;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out       = r_out;
        mul_en      = 1'b0;
        mul_op      = r_h;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_h = base_h;
                    if (!r_inside && (in_len == '0)) begin
                        // empty key: byte ignored, straight to finalisation
                        n_state = S_FIN;
                    end else begin
                        n_inside = 1'b1;
                        n_last   = s_axis_tlast;
                        if (base_phase == 2'd3) begin
                            mul_en  = 1'b1;
                            mul_op  = {in_byte, base_pend};
                            n_pend  = 24'd0;
                            n_phase = 2'd0;
                            n_state = S_K1;
                        end else begin
                            unique case (base_phase)
                                2'd0:    n_pend = {16'd0, in_byte};
                                2'd1:    n_pend = {8'd0, in_byte, base_pend[7:0]};
                                default: n_pend = {in_byte, base_pend[15:0]};
                            endcase
                            n_phase = base_phase + 2'd1;
                            if (s_axis_tlast) begin
                                n_state = S_TAIL;
                            end
                        end
                    end
                end
            end
            S_K1: begin
                mul_en  = 1'b1;
                mul_op  = k_shift;
                n_state = S_K2;
            end
            S_K2: begin
                n_k     = prod;
                mul_en  = 1'b1;
                mul_op  = r_h;
                n_state = S_H;
            end
            S_H: begin
                n_h     = prod ^ r_k;
                n_state = r_last ? S_FIN : S_IDLE;
            end
            S_TAIL: begin
                mul_en  = 1'b1;
                mul_op  = r_h ^ {8'd0, r_pend};
                n_state = S_TAIL_W;
            end
            S_TAIL_W: begin
                n_h     = prod;
                n_state = S_FIN;
            end
            S_FIN: begin
                mul_en  = 1'b1;
                mul_op  = r_h ^ (r_h >> FIN_SHIFT_A);
                n_state = S_FIN_W;
            end
            default: begin
                // hold the product until the output register is free
                if (out_free) begin
                    n_out       = fin_res;
                    n_out_valid = 1'b1;
                    n_h         = '0;
                    n_pend      = 24'd0;
                    n_phase     = 2'd0;
                    n_inside    = 1'b0;
                    n_state     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seed      <= '0;
            r_h         <= '0;
            r_pend      <= 24'd0;
            r_phase     <= 2'd0;
            r_inside    <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_h         <= n_h;
            r_pend      <= n_pend;
            r_phase     <= n_phase;
            r_inside    <= n_inside;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            if (i_seed_wr_en) begin
                r_seed <= i_seed_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_out <= n_out;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    a_plain_byte_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_inside && (r_phase != 2'd3) && !s_axis_tlast) |=> (r_state == S_IDLE))
        else $error("plain byte did not return to idle");

    a_hash_delivered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN_W) && out_free) |=> (m_axis_tvalid && !r_inside))
        else $error("finished hash not presented");

    a_word_clears_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_H) |-> (r_phase == 2'd0 && r_pend == 24'd0))
        else $error("pending bytes left after word mix");

    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_inside && (r_phase == 2'd3)) |=> (r_state == S_K1 && !s_axis_tready))
        else $error("word mix not started");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// self-checking bench for murmur2_hash_stream: byte stream in, 32-bit hash out
// hashes are predicted per accepted byte and compared in order with the m_axis output
// depends on mmh2_pkg and the design files
module tb;
    import mmh2_pkg::*;

    typedef enum logic { ROW_BYTE, ROW_SEED } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [7:0]  data;
        t_word       len;      // key length, or seed value for a seed row
        logic        last;
        bit          known;
        t_word       known_hash;
    } t_stim_row;

    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS  = 517;
    localparam int REPORT_MAX   = 10;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_seed_wr_en;
    logic [31:0] i_seed_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;     // [7:0] data_byte, [39:8] key_length
    logic        s_axis_tlast;     // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;     // [31:0] hash_value

    // predictor state
    t_word       seed_cfg   = '0;
    t_word       hash_acc   = '0;
    logic [23:0] tail_bytes = '0;
    logic [1:0]  tail_count = '0;
    bit          in_key     = 1'b0;

    t_word       hash_expected [$];
    t_stim_row   stim_rows [$];
    int          mismatch_count = 0;
    int          item_count     = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;

    murmur2_hash_stream uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_seed_wr_en   (i_seed_wr_en),
        .i_seed_wr_data (i_seed_wr_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic t_word murmur_finish(input t_word h);
        t_word x;
        x = h ^ (h >> FIN_SHIFT_A);
        x = x * MIX_MUL;
        x = x ^ (x >> FIN_SHIFT_B);
        return x;
    endfunction

    function automatic void key_state_clear();
        hash_acc   = '0;
        tail_bytes = '0;
        tail_count = '0;
        in_key     = 1'b0;
    endfunction

    function automatic void murmur_absorb(input logic [7:0] b, input t_word len,
                                          input logic last, output bit emit,
                                          output t_word hash_out);
        t_word k;
        t_word h;
        emit     = 1'b0;
        hash_out = '0;
        if (!in_key) begin
            hash_acc   = seed_cfg ^ len;
            tail_bytes = '0;
            tail_count = '0;
            if (len == '0) begin
                // empty key: hashed at once, byte and mark ignored
                emit     = 1'b1;
                hash_out = murmur_finish(hash_acc);
                key_state_clear();
                return;
            end
            in_key = 1'b1;
        end
        if (tail_count < 2'd3) begin
            tail_bytes = tail_bytes | (24'(b) << (8 * tail_count));
            tail_count = tail_count + 2'd1;
        end else begin
            k = {b, tail_bytes};
            k = k * MIX_MUL;
            k = k ^ (k >> MIX_SHIFT);
            k = k * MIX_MUL;
            hash_acc   = (hash_acc * MIX_MUL) ^ k;
            tail_bytes = '0;
            tail_count = '0;
        end
        if (last) begin
            h = hash_acc;
            if (tail_count != 2'd0) begin
                h = h ^ {8'h00, tail_bytes};
                h = h * MIX_MUL;
            end
            emit     = 1'b1;
            hash_out = murmur_finish(h);
            key_state_clear();
        end
    endfunction

    // one transaction on s_axis; valid stays high into the next byte unless a gap is drawn
    task automatic push_byte(input logic [7:0] b, input t_word len, input logic last,
                             input bit known, input t_word known_hash);
        bit    emit;
        t_word h;
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {len, b};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        item_count++;
        murmur_absorb(b, len, last, emit, h);
        if (emit)
            hash_expected.push_back(known ? known_hash : h);
    endtask

    // seed changes only once the block has gone quiet
    task automatic write_seed(input t_word value);
        s_axis_tvalid <= 1'b0;
        while (hash_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_seed_wr_en   <= 1'b1;
        i_seed_wr_data <= value;
        @(posedge i_clk);
        i_seed_wr_en <= 1'b0;
        seed_cfg = value;
    endtask

    task automatic run_random_keys(input int target);
        int          nbytes;
        int unsigned pick;
        t_word       len_field;
        logic        last;
        int          stop_at;
        stop_at = item_count + target;
        while (item_count < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 5)
                nbytes = 0;
            else if (pick < 75)
                nbytes = $urandom_range(12, 1);
            else if (pick < 96)
                nbytes = $urandom_range(40, 13);
            else
                nbytes = $urandom_range(160, 41);
            len_field = nbytes;
            // broken sequences: a length that disagrees with the bytes sent
            if (nbytes != 0 && $urandom_range(99) < 12)
                len_field = ($urandom_range(1) != 0) ? $urandom : $urandom_range(8, 1);
            if (nbytes == 0) begin
                push_byte(8'($urandom_range(255)), '0, 1'($urandom_range(1)), 1'b0, '0);
            end else begin
                for (int i = 0; i < nbytes; i++) begin
                    last = (i == nbytes - 1) || ($urandom_range(199) == 0);
                    push_byte(8'($urandom_range(255)),
                              (i == 0) ? len_field : t_word'($urandom),
                              last, 1'b0, '0);
                end
            end
            if ($urandom_range(99) < 2)
                write_seed($urandom);
        end
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (hash_expected.size() == 0) begin
                if (mismatch_count < REPORT_MAX)
                    $display("unexpected hash %08h, none pending", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = hash_expected.pop_front();
                if (m_axis_tdata !== want) begin
                    if (mismatch_count < REPORT_MAX)
                        $display("hash mismatch: expected %08h, got %08h", want, m_axis_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_seed_wr_en   <= 1'b0;
        i_seed_wr_data <= '0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        s_axis_tlast   <= 1'b0;

        // empty keys under a zero seed hash to zero
        stim_rows.push_back('{ROW_BYTE, 8'hab, 32'd0, 1'b0, 1'b1, 32'h0});
        stim_rows.push_back('{ROW_BYTE, 8'hff, 32'd0, 1'b1, 1'b1, 32'h0});
        // single byte keys
        stim_rows.push_back('{ROW_BYTE, 8'h00, 32'd1, 1'b1, 1'b0, 32'h0});
        stim_rows.push_back('{ROW_BYTE, 8'hff, 32'd1, 1'b1, 1'b0, 32'h0});
        // one whole word, length field ignored after the first byte
        stim_rows.push_back('{ROW_BYTE, 8'h01, 32'd4, 1'b0, 1'b0, 32'h0});
        stim_rows.push_back('{ROW_BYTE, 8'h02, 32'hffffffff, 1'b0, 1'b0, 32'h0});
        stim_rows.push_back('{ROW_BYTE, 8'h03, 32'd0, 1'b0, 1'b0, 32'h0});
        stim_rows.push_back('{ROW_BYTE, 8'h04, 32'd0, 1'b1, 1'b0, 32'h0});
        // word plus one leftover byte, all ones
        stim_rows.push_back('{ROW_BYTE, 8'hff, 32'd5, 1'b0, 1'b0, 32'h0});
        stim_rows.push_back('{ROW_BYTE, 8'hff, 32'd0, 1'b0, 1'b0, 32'h0});
        stim_rows.push_back('{ROW_BYTE, 8'hff, 32'd0, 1'b0, 1'b0, 32'h0});
        stim_rows.push_back('{ROW_BYTE, 8'hff, 32'd0, 1'b0, 1'b0, 32'h0});
        stim_rows.push_back('{ROW_BYTE, 8'hff, 32'd0, 1'b1, 1'b0, 32'h0});
        // length says two, three bytes arrive
        stim_rows.push_back('{ROW_BYTE, 8'h5a, 32'd2, 1'b0, 1'b0, 32'h0});
        stim_rows.push_back('{ROW_BYTE, 8'ha5, 32'd0, 1'b0, 1'b0, 32'h0});
        stim_rows.push_back('{ROW_BYTE, 8'h3c, 32'd0, 1'b1, 1'b0, 32'h0});
        // maximum length, two bytes
        stim_rows.push_back('{ROW_BYTE, 8'h11, 32'hffffffff, 1'b0, 1'b0, 32'h0});
        stim_rows.push_back('{ROW_BYTE, 8'h22, 32'd0, 1'b1, 1'b0, 32'h0});
        // seed written mid-key only applies from the next key
        stim_rows.push_back('{ROW_BYTE, 8'h80, 32'd3, 1'b0, 1'b0, 32'h0});
        stim_rows.push_back('{ROW_SEED, 8'h00, 32'h12345678, 1'b0, 1'b0, 32'h0});
        stim_rows.push_back('{ROW_BYTE, 8'h7f, 32'd0, 1'b0, 1'b0, 32'h0});
        stim_rows.push_back('{ROW_BYTE, 8'h01, 32'd0, 1'b1, 1'b0, 32'h0});
        stim_rows.push_back('{ROW_BYTE, 8'h00, 32'd0, 1'b0, 1'b0, 32'h0});
        // all-ones seed against all-ones length cancels to zero
        stim_rows.push_back('{ROW_SEED, 8'h00, 32'hffffffff, 1'b0, 1'b0, 32'h0});
        stim_rows.push_back('{ROW_BYTE, 8'h00, 32'hffffffff, 1'b1, 1'b1, 32'h0});
        stim_rows.push_back('{ROW_BYTE, 8'h9c, 32'd0, 1'b0, 1'b0, 32'h0});

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 31;
        recv_idle_pct = 80;
        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_SEED)
                write_seed(stim_rows[i].len);
            else
                push_byte(stim_rows[i].data, stim_rows[i].len, stim_rows[i].last,
                          stim_rows[i].known, stim_rows[i].known_hash);
        end

        write_seed($urandom);
        run_random_keys(PHASE_ITEMS);

        write_seed(32'hffffffff);
        send_idle_pct = 80;
        recv_idle_pct = 31;
        run_random_keys(PHASE_ITEMS);

        write_seed(32'h0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_keys(PHASE_ITEMS);

        s_axis_tvalid <= 1'b0;
        while (hash_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && hash_expected.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
